// ----- rtl/core/avr_alu_pkg.sv -----
// Package for the AVR register-instruction execute block.
// Holds the beat payload types, operation codes and status bit positions; no dependencies.
package avr_alu_pkg;

  typedef struct packed {
    logic [5:0] operation;
    logic [4:0] dest_index;
    logic [4:0] source_index;
    logic [7:0] immediate;
    logic [2:0] bit_select;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  write_kind;
    logic [4:0]  write_index;
    logic [15:0] write_value;
    logic [7:0]  status_after;
    logic        take_or_skip;
  } out_beat_t;

  localparam logic [5:0] OP_ADC = 6'd0, OP_ADD = 6'd1, OP_ADIW = 6'd2, OP_AND = 6'd3,
    OP_ANDI = 6'd4, OP_ASR = 6'd5, OP_BCLR = 6'd6, OP_BLD = 6'd7, OP_BRBC = 6'd8,
    OP_BRBS = 6'd9, OP_BSET = 6'd10, OP_BST = 6'd11, OP_COM = 6'd12, OP_CP = 6'd13,
    OP_CPC = 6'd14, OP_CPI = 6'd15, OP_CPSE = 6'd16, OP_DEC = 6'd17, OP_EOR = 6'd18,
    OP_FMUL = 6'd19, OP_FMULS = 6'd20, OP_FMULSU = 6'd21, OP_INC = 6'd22, OP_LDI = 6'd23,
    OP_LSR = 6'd24, OP_MOV = 6'd25, OP_MOVW = 6'd26, OP_MUL = 6'd27, OP_MULS = 6'd28,
    OP_MULSU = 6'd29, OP_NEG = 6'd30, OP_OR = 6'd31, OP_ORI = 6'd32, OP_SBC = 6'd33,
    OP_SBCI = 6'd34, OP_SUBI = 6'd35, OP_SUB = 6'd36;

  localparam logic [1:0] WK_NONE = 2'd0, WK_BYTE = 2'd1, WK_PAIR = 2'd2;

  localparam int FL_C = 0, FL_Z = 1, FL_N = 2, FL_V = 3, FL_S = 4, FL_H = 5, FL_T = 6;

endpackage

// ----- rtl/core/avr_alu_exec.sv -----
// Combinational execute of one AVR register instruction: operands in, result and flags out.
// Depends on avr_alu_pkg.
module avr_alu_exec (
  input  avr_alu_pkg::in_beat_t  ins,
  input  logic [7:0]             rd,
  input  logic [7:0]             rr,
  input  logic [7:0]             rhd,
  input  logic [7:0]             rhr,
  input  logic [7:0]             rld,
  input  logic [7:0]             rlr,
  input  logic [7:0]             rp_lo,
  input  logic [7:0]             rp_hi,
  input  logic [7:0]             sreg,
  output avr_alu_pkg::out_beat_t res
);

  logic [7:0]  a, b, r, sr;
  logic        cin, sub, keepz, arith, logic_op, zf, vf, nf;
  logic [7:0]  cy;
  logic [15:0] w, wr;
  logic signed [17:0] prod;
  logic [15:0] pr;
  logic        frac, is_mul;

  always_comb begin
    sr = sreg;
    res = '0;
    a = rd;
    b = rr;
    cin = 1'b0;
    sub = 1'b0;
    keepz = 1'b0;
    arith = 1'b0;
    logic_op = 1'b0;
    r = 8'h00;
    cy = 8'h00;
    vf = 1'b0;
    nf = 1'b0;
    zf = 1'b0;
    w = '0;
    wr = '0;
    prod = '0;
    pr = '0;
    frac = 1'b0;
    is_mul = 1'b0;
    case (ins.operation)
      avr_alu_pkg::OP_ADC: begin arith = 1'b1; cin = sreg[0]; end
      avr_alu_pkg::OP_ADD: arith = 1'b1;
      avr_alu_pkg::OP_SUB, avr_alu_pkg::OP_CP: begin arith = 1'b1; sub = 1'b1; end
      avr_alu_pkg::OP_SBC, avr_alu_pkg::OP_CPC: begin
        arith = 1'b1; sub = 1'b1; cin = sreg[0]; keepz = 1'b1;
      end
      avr_alu_pkg::OP_CPI, avr_alu_pkg::OP_SUBI: begin
        arith = 1'b1; sub = 1'b1; a = rhd; b = ins.immediate;
      end
      avr_alu_pkg::OP_SBCI: begin
        arith = 1'b1; sub = 1'b1; a = rhd; b = ins.immediate; cin = sreg[0]; keepz = 1'b1;
      end
      default: ;
    endcase
    if (arith) begin
      if (sub) begin
        r = a - b - {7'd0, cin};
        cy = (~a & b) | (b & r) | (r & ~a);
        vf = (a[7] & ~b[7] & ~r[7]) | (~a[7] & b[7] & r[7]);
      end else begin
        r = a + b + {7'd0, cin};
        cy = (a & b) | (b & ~r) | (~r & a);
        vf = (a[7] & b[7] & ~r[7]) | (~a[7] & ~b[7] & r[7]);
      end
      sr[avr_alu_pkg::FL_H] = cy[3];
      sr[avr_alu_pkg::FL_C] = cy[7];
    end
    case (ins.operation)
      avr_alu_pkg::OP_AND: begin r = rd & rr; logic_op = 1'b1; end
      avr_alu_pkg::OP_ANDI: begin r = rhd & ins.immediate; logic_op = 1'b1; end
      avr_alu_pkg::OP_OR: begin r = rd | rr; logic_op = 1'b1; end
      avr_alu_pkg::OP_ORI: begin r = rhd | ins.immediate; logic_op = 1'b1; end
      avr_alu_pkg::OP_EOR: begin r = rd ^ rr; logic_op = 1'b1; end
      avr_alu_pkg::OP_COM: begin r = ~rd; logic_op = 1'b1; sr[avr_alu_pkg::FL_C] = 1'b1; end
      avr_alu_pkg::OP_ASR, avr_alu_pkg::OP_LSR: begin
        r = {(ins.operation == avr_alu_pkg::OP_ASR) & rd[7], rd[7:1]};
        logic_op = 1'b1;
        vf = r[7] ^ rd[0];
        sr[avr_alu_pkg::FL_C] = rd[0];
      end
      avr_alu_pkg::OP_DEC: begin r = rd - 8'd1; logic_op = 1'b1; vf = (r == 8'h7F); end
      avr_alu_pkg::OP_INC: begin r = rd + 8'd1; logic_op = 1'b1; vf = (r == 8'h80); end
      avr_alu_pkg::OP_NEG: begin
        r = 8'd0 - rd;
        logic_op = 1'b1;
        vf = (r == 8'h80);
        sr[avr_alu_pkg::FL_H] = r[3] | rd[3];
        sr[avr_alu_pkg::FL_C] = (r != 8'd0);
      end
      default: ;
    endcase
    if (arith || logic_op) begin
      nf = r[7];
      zf = (r == 8'd0) & (~keepz | sreg[avr_alu_pkg::FL_Z]);
      sr[avr_alu_pkg::FL_N] = nf;
      sr[avr_alu_pkg::FL_Z] = zf;
      sr[avr_alu_pkg::FL_V] = vf;
      sr[avr_alu_pkg::FL_S] = nf ^ vf;
    end
    case (ins.operation)
      avr_alu_pkg::OP_FMUL: begin
        prod = $signed({10'd0, rld}) * $signed({10'd0, rlr}); frac = 1'b1; is_mul = 1'b1;
      end
      avr_alu_pkg::OP_FMULS: begin
        prod = $signed({{10{rld[7]}}, rld}) * $signed({{10{rlr[7]}}, rlr});
        frac = 1'b1; is_mul = 1'b1;
      end
      avr_alu_pkg::OP_FMULSU: begin
        prod = $signed({{10{rld[7]}}, rld}) * $signed({10'd0, rlr}); frac = 1'b1; is_mul = 1'b1;
      end
      avr_alu_pkg::OP_MUL: begin
        prod = $signed({10'd0, rd}) * $signed({10'd0, rr}); is_mul = 1'b1;
      end
      avr_alu_pkg::OP_MULS: begin
        prod = $signed({{10{rhd[7]}}, rhd}) * $signed({{10{rhr[7]}}, rhr}); is_mul = 1'b1;
      end
      avr_alu_pkg::OP_MULSU: begin
        prod = $signed({{10{rld[7]}}, rld}) * $signed({10'd0, rlr}); is_mul = 1'b1;
      end
      default: ;
    endcase
    if (is_mul) begin
      pr = frac ? {prod[14:0], 1'b0} : prod[15:0];
      sr[avr_alu_pkg::FL_C] = prod[15];
      sr[avr_alu_pkg::FL_Z] = (pr == 16'd0);
      res.write_kind = avr_alu_pkg::WK_PAIR;
      res.write_index = 5'd0;
      res.write_value = pr;
    end
    if (arith || logic_op) begin
      if (ins.operation != avr_alu_pkg::OP_CP && ins.operation != avr_alu_pkg::OP_CPC &&
          ins.operation != avr_alu_pkg::OP_CPI) begin
        res.write_kind = avr_alu_pkg::WK_BYTE;
        res.write_value = {8'd0, r};
        res.write_index = (ins.operation == avr_alu_pkg::OP_ANDI ||
                           ins.operation == avr_alu_pkg::OP_ORI ||
                           ins.operation == avr_alu_pkg::OP_SBCI ||
                           ins.operation == avr_alu_pkg::OP_SUBI) ?
                          {1'b1, ins.dest_index[3:0]} : ins.dest_index;
      end
    end
    case (ins.operation)
      avr_alu_pkg::OP_ADIW: begin
        w = {rp_hi, rp_lo};
        wr = w + {10'd0, ins.immediate[5:0]};
        sr[avr_alu_pkg::FL_C] = ~wr[15] & w[15];
        sr[avr_alu_pkg::FL_N] = wr[15];
        sr[avr_alu_pkg::FL_Z] = (wr == 16'd0);
        sr[avr_alu_pkg::FL_V] = ~w[15] & wr[15];
        sr[avr_alu_pkg::FL_S] = wr[15] ^ (~w[15] & wr[15]);
        res.write_kind = avr_alu_pkg::WK_PAIR;
        res.write_index = {2'b11, ins.dest_index[2:1], 1'b0};
        res.write_value = wr;
      end
      avr_alu_pkg::OP_MOVW: begin
        res.write_kind = avr_alu_pkg::WK_PAIR;
        res.write_index = {ins.dest_index[4:1], 1'b0};
        res.write_value = {rp_hi, rp_lo};
      end
      avr_alu_pkg::OP_BCLR: sr[ins.bit_select] = 1'b0;
      avr_alu_pkg::OP_BSET: sr[ins.bit_select] = 1'b1;
      avr_alu_pkg::OP_BST: sr[avr_alu_pkg::FL_T] = rd[ins.bit_select];
      avr_alu_pkg::OP_BLD: begin
        r = rd;
        r[ins.bit_select] = sreg[avr_alu_pkg::FL_T];
        res.write_kind = avr_alu_pkg::WK_BYTE;
        res.write_index = ins.dest_index;
        res.write_value = {8'd0, r};
      end
      avr_alu_pkg::OP_BRBC: res.take_or_skip = ~sreg[ins.bit_select];
      avr_alu_pkg::OP_BRBS: res.take_or_skip = sreg[ins.bit_select];
      avr_alu_pkg::OP_CPSE: res.take_or_skip = (rd == rr);
      avr_alu_pkg::OP_LDI: begin
        res.write_kind = avr_alu_pkg::WK_BYTE;
        res.write_index = {1'b1, ins.dest_index[3:0]};
        res.write_value = {8'd0, ins.immediate};
      end
      avr_alu_pkg::OP_MOV: begin
        res.write_kind = avr_alu_pkg::WK_BYTE;
        res.write_index = ins.dest_index;
        res.write_value = {8'd0, rr};
      end
      default: ;
    endcase
    res.status_after = sr;
  end

endmodule

// ----- rtl/core/avr_alu_register_execute.sv -----
// Top level of the AVR register-instruction execute block.
// Depends on avr_alu_pkg and avr_alu_exec.
// One beat per cycle is sustained while out_ready is high; each accepted beat goes into the result register.
// The accepted input beat feeds a single combinational execute pass into the result register,
// and the register file and status register update on the same edge as the result.
// A stalled result holds the input side. Reset clears registers, status and valids.
module avr_alu_register_execute (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  avr_alu_pkg::in_beat_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output avr_alu_pkg::out_beat_t out_data
);

  logic [7:0]             rf_r [32];
  logic [7:0]             sreg_r;
  logic                   ov_r;
  avr_alu_pkg::out_beat_t out_r;
  avr_alu_pkg::out_beat_t res;
  logic                   fire;
  logic [4:0]             pi;

  assign in_ready = ~ov_r | out_ready;
  assign fire = in_valid & in_ready;
  assign out_valid = ov_r;
  assign out_data = out_r;

  always_comb begin
    if (in_data.operation == avr_alu_pkg::OP_ADIW) begin
      pi = {2'b11, in_data.dest_index[2:1], 1'b0};
    end else begin
      pi = {in_data.source_index[4:1], 1'b0};
    end
  end

  avr_alu_exec u_exec (
    .ins   (in_data),
    .rd    (rf_r[in_data.dest_index]),
    .rr    (rf_r[in_data.source_index]),
    .rhd   (rf_r[{1'b1, in_data.dest_index[3:0]}]),
    .rhr   (rf_r[{1'b1, in_data.source_index[3:0]}]),
    .rld   (rf_r[{2'b10, in_data.dest_index[2:0]}]),
    .rlr   (rf_r[{2'b10, in_data.source_index[2:0]}]),
    .rp_lo (rf_r[pi]),
    .rp_hi (rf_r[{pi[4:1], 1'b1}]),
    .sreg  (sreg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sreg_r <= '0;
      for (int i = 0; i < 32; i++) rf_r[i] <= '0;
    end else begin
      if (fire) begin
        ov_r <= 1'b1;
        out_r <= res;
        sreg_r <= res.status_after;
        if (res.write_kind == avr_alu_pkg::WK_BYTE) begin
          rf_r[res.write_index] <= res.write_value[7:0];
        end else if (res.write_kind == avr_alu_pkg::WK_PAIR) begin
          rf_r[{res.write_index[4:1], 1'b0}] <= res.write_value[7:0];
          rf_r[{res.write_index[4:1], 1'b1}] <= res.write_value[15:8];
        end
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule
